// ----- rtl/two_column_interp_table_assert.svh -----
// Assertion macros shared by the interpolation table RTL.
`ifndef TWO_COLUMN_INTERP_TABLE_ASSERT_SVH
`define TWO_COLUMN_INTERP_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCIT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tcit_pkg.sv -----
// Shared constants, codes and types of the interpolation table.
`default_nettype none

package tcit_pkg;

	// Field widths
	localparam int unsigned DATA_W   = 16;
	localparam int unsigned IDX_W    = 4;
	localparam int unsigned CFG_W    = 5;
	localparam int unsigned REGION_W = 2;

	// Table depth default and register reset value
	localparam int unsigned      DEF_ENTRIES   = 16;
	localparam logic [CFG_W-1:0] ENTRIES_RESET = 5'd16;

	// Serial arithmetic: two multiplier bits per step, one quotient bit per step
	localparam int unsigned MUL_DIGIT = 2;
	localparam int unsigned MUL_STEPS = DATA_W / MUL_DIGIT;
	localparam int unsigned DIV_STEPS = DATA_W;
	localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
	localparam int unsigned ACC_W     = 2 * DATA_W + 1;

	// Transaction kinds
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	// Result regions
	localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd0;
	localparam logic [REGION_W-1:0] REGION_INTERP = 2'd1;
	localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd2;

	// One breakpoint row
	typedef struct packed {
		logic [DATA_W-1:0] axis;
		logic [DATA_W-1:0] first;
		logic [DATA_W-1:0] second;
	} row_t;

	// Operands handed to an interpolation lane
	typedef struct packed {
		logic [DATA_W-1:0] ya;
		logic [DATA_W-1:0] yb;
		logic [DATA_W-1:0] d_hi;
		logic [DATA_W-1:0] d_lo;
		logic [DATA_W-1:0] span;
	} lane_op_t;

endpackage

`default_nettype wire

// ----- rtl/tcit_store.sv -----
// Breakpoint memory: one write port, two registered read ports.
`default_nettype none

module tcit_store import tcit_pkg::*; #(
	parameter int unsigned ENTRIES = DEF_ENTRIES
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
	input  wire row_t                       wr_row,
	input  wire logic [$clog2(ENTRIES)-1:0] rd_addr_a,
	input  wire logic [$clog2(ENTRIES)-1:0] rd_addr_b,
	output row_t                            rd_row_a,
	output row_t                            rd_row_b
);

	row_t mem_q [ENTRIES];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
	end

	// Registered read ports
	always_ff @(posedge clk) begin
		rd_row_a <= mem_q[rd_addr_a];
		rd_row_b <= mem_q[rd_addr_b];
	end

endmodule

`default_nettype wire

// ----- rtl/tcit_lane.sv -----
// One interpolation lane: serial shift-add multiply then restoring divide.
`default_nettype none

module tcit_lane import tcit_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire lane_op_t          op,
	output logic                   done,
	output logic [DATA_W-1:0]      result
);

	`include "two_column_interp_table_assert.svh"

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_DIV  = 2'd2;

	localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_STEPS - 1);
	localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

	logic [1:0]        phase_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic [DATA_W-1:0] ya_q;
	logic [DATA_W-1:0] yb_q;
	logic [DATA_W-1:0] dh_q;
	logic [DATA_W-1:0] dl_q;
	logic [DATA_W-1:0] span_q;
	logic [ACC_W-1:0]  acc_q;

	logic [ACC_W-1:0]    acc_mul;
	logic [DATA_W+1:0]   trial;
	logic                trial_ge;
	logic [DATA_W+1:0]   trial_diff;
	logic [DATA_W:0]     rem_next;
	logic [ACC_W-1:0]    acc_div;

	// y times one two-bit multiplier digit
	function automatic logic [DATA_W+1:0] digit_mul(input logic [DATA_W-1:0] y,
			input logic [MUL_DIGIT-1:0] d);
		logic [DATA_W+1:0] y_ext;
		y_ext = (DATA_W+2)'(y);
		case (d)
			2'd0:    digit_mul = '0;
			2'd1:    digit_mul = y_ext;
			2'd2:    digit_mul = y_ext << 1;
			2'd3:    digit_mul = y_ext + (y_ext << 1);
			default: digit_mul = '0;
		endcase
	endfunction

	// Multiply step: both products summed, most significant digit first
	assign acc_mul = {acc_q[ACC_W-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}}
		+ ACC_W'(digit_mul(ya_q, dh_q[DATA_W-1 -: MUL_DIGIT]))
		+ ACC_W'(digit_mul(yb_q, dl_q[DATA_W-1 -: MUL_DIGIT]));

	// Divide step: remainder in the top bits, quotient shifts in at the bottom
	assign trial      = {acc_q[ACC_W-1:DATA_W], acc_q[DATA_W-1]};
	assign trial_ge   = trial >= {2'b00, span_q};
	assign trial_diff = trial - {2'b00, span_q};
	assign rem_next   = trial_ge ? trial_diff[DATA_W:0] : trial[DATA_W:0];
	assign acc_div    = {rem_next, acc_q[DATA_W-2:0], trial_ge};

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			// one-cycle pulse after the last divide step
			done_q <= (phase_q == PH_DIV) && (cnt_q == DIV_LAST);
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_MUL;
						cnt_q   <= '0;
					end
				end
				PH_MUL: begin
					if (cnt_q == MUL_LAST) begin
						phase_q <= PH_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_DIV: begin
					if (cnt_q == DIV_LAST) begin
						phase_q <= PH_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	// Datapath shift registers
	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && start) begin
			ya_q   <= op.ya;
			yb_q   <= op.yb;
			dh_q   <= op.d_hi;
			dl_q   <= op.d_lo;
			span_q <= op.span;
			acc_q  <= '0;
		end else if (phase_q == PH_MUL) begin
			acc_q <= acc_mul;
			dh_q  <= dh_q << MUL_DIGIT;
			dl_q  <= dl_q << MUL_DIGIT;
		end else if (phase_q == PH_DIV) begin
			acc_q <= acc_div;
		end
	end

	assign done   = done_q;
	assign result = acc_q[DATA_W-1:0];

	`TCIT_ASSERT_IMPLY(a_span_nonzero, clk, arst_n, start, op.span != '0, "zero-width segment started")
	`TCIT_ASSERT_NEXT(a_rem_below_span, clk, arst_n, (phase_q == PH_MUL) && (cnt_q == MUL_LAST), acc_q[ACC_W-1:DATA_W] < {1'b0, span_q}, "quotient would overflow")
	`TCIT_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q, "done held for more than one cycle")

endmodule

`default_nettype wire

// ----- rtl/two_column_interp_table.sv -----
// Lookup of a two-column breakpoint table with linear interpolation.
// Write transactions: taken one per cycle while no lookup is in progress, no result.
// Lookup: scans entries 0..N-1 through one memory read port (N = entries in use),
// then interpolates both columns in two serial lanes (8 multiply + 16 divide steps).
// Clamped lookups bypass the lanes; one lookup at a time.
// Reset clears control and sets entries_in_use to 16; table contents are undefined until written.
`default_nettype none

module two_column_interp_table import tcit_pkg::*; #(
	parameter int unsigned ENTRIES = DEF_ENTRIES
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_write,
	input  wire logic [CFG_W-1:0]    cfg_data,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire logic                action,
	input  wire logic [IDX_W-1:0]    entry_index,
	input  wire logic [DATA_W-1:0]   axis_value,
	input  wire logic [DATA_W-1:0]   first_value,
	input  wire logic [DATA_W-1:0]   second_value,
	input  wire logic [DATA_W-1:0]   query_point,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic [DATA_W-1:0]        first_result,
	output logic [DATA_W-1:0]        second_result,
	output logic [REGION_W-1:0]      region
);

	`include "two_column_interp_table_assert.svh"

	localparam int unsigned IW = $clog2(ENTRIES);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;
	localparam logic [2:0] ST_CALC  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]          state_q;
	logic [CFG_W-1:0]    entries_in_use_q;
	logic                scan_issue_q;
	logic                scan_v_s1;
	logic [IW-1:0]       scan_i_s1;
	logic [IW-1:0]       scan_idx_q;
	logic [IW-1:0]       seg_q;
	logic                below_q;
	logic [REGION_W-1:0] region_q;
	logic [DATA_W-1:0]   query_q;
	logic [DATA_W-1:0]   res1_q;
	logic [DATA_W-1:0]   res2_q;
	logic                result_valid_q;
	logic [DATA_W-1:0]   first_result_q;
	logic [DATA_W-1:0]   second_result_q;
	logic [REGION_W-1:0] region_out_q;

	logic          item_acc;
	logic          wr_en;
	row_t          wr_row;
	logic [IW-1:0] last_idx;
	logic [IW-1:0] rd_addr_a;
	logic [IW-1:0] seg_next;
	row_t          rd_row_a;
	row_t          rd_row_b;
	logic          below_now;
	logic          out_free;
	logic          lane_start;
	lane_op_t      first_op;
	lane_op_t      second_op;
	logic          first_done;
	logic          second_done;
	logic [DATA_W-1:0] first_lane_res;
	logic [DATA_W-1:0] second_lane_res;

	// Handshake
	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign out_free   = !result_valid_q || !result_stall;

	// Index of the last breakpoint in use, register clamped to 1..ENTRIES
	always_comb begin
		if (entries_in_use_q == '0) begin
			last_idx = '0;
		end else if (32'(entries_in_use_q) > 32'(ENTRIES)) begin
			last_idx = IW'(ENTRIES - 1);
		end else begin
			last_idx = IW'(entries_in_use_q - 5'd1);
		end
	end

	// Table writes; indexes past the table are dropped
	assign wr_en  = item_acc && (action == ACT_WRITE) && (32'(entry_index) < 32'(ENTRIES));
	assign wr_row = '{axis: axis_value, first: first_value, second: second_value};

	// Read port A walks the table during the scan, then picks the segment start (or the end entry when clamped)
	assign seg_next = seg_q + IW'(1);
	always_comb begin
		rd_addr_a = scan_idx_q;
		if (state_q == ST_FETCH) begin
			case (region_q)
				REGION_BELOW: rd_addr_a = '0;
				REGION_ABOVE: rd_addr_a = last_idx;
				default:      rd_addr_a = seg_q;
			endcase
		end
	end

	tcit_store #(
		.ENTRIES (ENTRIES)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (IW'(entry_index)),
		.wr_row    (wr_row),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (seg_next),
		.rd_row_a  (rd_row_a),
		.rd_row_b  (rd_row_b)
	);

	// Below-first test taken from entry 0 as it arrives
	assign below_now = (scan_i_s1 == '0) ? (query_q < rd_row_a.axis) : below_q;

	// Lane operands
	assign lane_start = (state_q == ST_LOAD) && (region_q == REGION_INTERP);
	always_comb begin
		first_op.ya   = rd_row_a.first;
		first_op.yb   = rd_row_b.first;
		first_op.d_hi = rd_row_b.axis - query_q;
		first_op.d_lo = query_q - rd_row_a.axis;
		first_op.span = rd_row_b.axis - rd_row_a.axis;
		second_op     = first_op;
		second_op.ya  = rd_row_a.second;
		second_op.yb  = rd_row_b.second;
	end

	tcit_lane u_first_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.op     (first_op),
		.done   (first_done),
		.result (first_lane_res)
	);

	tcit_lane u_second_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.op     (second_op),
		.done   (second_done),
		.result (second_lane_res)
	);

	// Control state and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			entries_in_use_q <= ENTRIES_RESET;
			scan_issue_q     <= 1'b0;
			scan_v_s1        <= 1'b0;
			result_valid_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				entries_in_use_q <= cfg_data;
			end
			// Result flag: set from the output state, cleared once taken
			if (state_q == ST_OUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			scan_v_s1 <= (state_q == ST_SCAN) && scan_issue_q;
			case (state_q)
				ST_IDLE: begin
					if (item_acc && action == ACT_LOOKUP) begin
						state_q      <= ST_SCAN;
						scan_issue_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (scan_issue_q && scan_idx_q == last_idx) begin
						scan_issue_q <= 1'b0;
					end
					if (scan_v_s1 && scan_i_s1 == last_idx) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: state_q <= ST_LOAD;
				ST_LOAD: begin
					state_q <= (region_q == REGION_INTERP) ? ST_CALC : ST_OUT;
				end
				ST_CALC: begin
					if (first_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Scan bookkeeping and result payload
	always_ff @(posedge clk) begin
		scan_i_s1 <= scan_idx_q;
		if (item_acc) begin
			query_q    <= query_point;
			scan_idx_q <= '0;
			seg_q      <= '0;
		end else if (state_q == ST_SCAN && scan_issue_q && scan_idx_q != last_idx) begin
			scan_idx_q <= scan_idx_q + IW'(1);
		end
		// Each arriving entry: segment start candidate, end-of-table region
		if (state_q == ST_SCAN && scan_v_s1) begin
			below_q <= below_now;
			if (scan_i_s1 != last_idx && rd_row_a.axis <= query_q) begin
				seg_q <= scan_i_s1;
			end
			if (scan_i_s1 == last_idx) begin
				if (below_now) begin
					region_q <= REGION_BELOW;
				end else if (query_q >= rd_row_a.axis) begin
					region_q <= REGION_ABOVE;
				end else begin
					region_q <= REGION_INTERP;
				end
			end
		end
		// Clamped lookups return the stored end values
		if (state_q == ST_LOAD && region_q != REGION_INTERP) begin
			res1_q <= rd_row_a.first;
			res2_q <= rd_row_a.second;
		end
		if (state_q == ST_CALC && first_done) begin
			res1_q <= first_lane_res;
			res2_q <= second_lane_res;
		end
		// Output register
		if (state_q == ST_OUT && out_free) begin
			first_result_q  <= res1_q;
			second_result_q <= res2_q;
			region_out_q    <= region_q;
		end
	end

	assign result_valid  = result_valid_q;
	assign first_result  = first_result_q;
	assign second_result = second_result_q;
	assign region        = region_out_q;

	`TCIT_ASSERT_IMPLY(a_lanes_in_step, clk, arst_n, state_q == ST_CALC, first_done == second_done, "lanes out of step")
	`TCIT_ASSERT_IMPLY(a_seg_before_last, clk, arst_n, lane_start, seg_q < last_idx, "segment start past last entry")
	`TCIT_ASSERT_IMPLY(a_result_from_out, clk, arst_n, $rose(result_valid_q), $past(state_q) == ST_OUT, "result raised outside output state")

endmodule

`default_nettype wire
